### rtl/exp_golomb_field_decoder_unit_assert.svh
// Assertion macros for the exp-Golomb field decoder checker.
`ifndef EXP_GOLOMB_FIELD_DECODER_UNIT_ASSERT_SVH
`define EXP_GOLOMB_FIELD_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EGD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("egd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define EGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("egd assertion failed");

`endif

### rtl/egd_pkg.sv
// Shared types, constants and helpers for the exp-Golomb field decoder.
package egd_pkg;

  localparam int WINDOW_BITS    = 64;
  localparam int CBP_TABLE_SIZE = 48;
  localparam int MAX_FIXED_LEN  = 32;

  // Bits of the window that count as bitstream.
  localparam logic [63:0] WIN_MASK = ~((64'd1 << (64 - WINDOW_BITS)) - 64'd1);

  typedef enum logic [1:0] {
    OP_UE = 2'd0,
    OP_SE = 2'd1,
    OP_ME = 2'd2,
    OP_UN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Intra coded_block_pattern mapping for me(v).
  localparam logic [5:0] CBP_MAP [CBP_TABLE_SIZE] = '{
    6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
    6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
    6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
    6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
    6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
  };

  // Leading zero count of a 32-bit word, 32 when the word is zero.
  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

endpackage

### rtl/exp_golomb_field_decoder_unit.sv
// Throughput: one field per cycle; the five register stages share one advance
// enable, so a held out_ready freezes every stage and in_ready drops with it.
// Stages: align, leading-zero count, left align, right shift, value map.
// Reset: synchronous active-high rst clears all stage valid bits; payload is not reset.
module exp_golomb_field_decoder_unit
  import egd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [63:0]        bit_window,
  input  logic [2:0]         bit_offset,
  input  logic [5:0]         field_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] value,
  output logic [5:0]         bits_used,
  output logic [3:0]         byte_advance,
  output logic [2:0]         next_offset,
  output logic [1:0]         status
);

  logic adv;

  // Stage 1: aligned window
  logic        s1_v;
  op_t         s1_op;
  logic [63:0] s1_bits;
  logic [2:0]  s1_off;
  logic [5:0]  s1_flen;
  logic [6:0]  s1_avail;

  // Stage 2: leading zeros
  logic        s2_v;
  op_t         s2_op;
  logic [63:0] s2_bits;
  logic [2:0]  s2_off;
  logic [5:0]  s2_flen;
  logic [6:0]  s2_avail;
  logic [5:0]  s2_lz;

  // Stage 3: field left aligned in 33 bits
  logic        s3_v;
  op_t         s3_op;
  logic [2:0]  s3_off;
  logic [32:0] s3_top;
  logic [5:0]  s3_rsh;
  logic        s3_fail;
  logic [5:0]  s3_used;

  // Stage 4: field right aligned
  logic        s4_v;
  op_t         s4_op;
  logic [32:0] s4_field;
  logic [32:0] s4_code;
  logic        s4_fail;
  logic [5:0]  s4_used;
  logic [6:0]  s4_total;

  // Combinational helpers
  logic [5:0]  flen_clamped;
  logic [63:0] eg_shifted;
  logic        s2_eg;
  logic        s2_eg_fail;
  logic        s2_un_fail;
  logic [32:0] s3_shifted;
  logic        me_in_range;
  logic signed [32:0] value_next;
  status_t     status_next;

  // The whole pipeline moves when the output slot is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      out_valid <= s4_v;
    end
  end

  // Stage 1: drop the bits before the field start, clamp the fixed length
  assign flen_clamped = (field_length > 6'(MAX_FIXED_LEN)) ? 6'(MAX_FIXED_LEN) : field_length;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op    <= op_t'(op);
      s1_bits  <= (bit_window & WIN_MASK) << bit_offset;
      s1_off   <= bit_offset;
      s1_flen  <= flen_clamped;
      s1_avail <= 7'(WINDOW_BITS) - {4'd0, bit_offset};
    end
  end

  // Stage 2: count the prefix zeros
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op    <= s1_op;
      s2_bits  <= s1_bits;
      s2_off   <= s1_off;
      s2_flen  <= s1_flen;
      s2_avail <= s1_avail;
      s2_lz    <= lzc32(s1_bits[63:32]);
    end
  end

  // Stage 3: check fit; for exp-Golomb bring the marker bit to the top, else take the fixed-length field
  assign s2_eg      = (s2_op != OP_UN);
  assign eg_shifted = s2_bits << s2_lz;
  assign s2_eg_fail = (s2_lz == 6'd32) || ({s2_lz, 1'b1} > s2_avail);
  assign s2_un_fail = ({1'b0, s2_flen} > s2_avail);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op  <= s2_op;
      s3_off <= s2_off;
      if (s2_eg) begin
        s3_top  <= eg_shifted[63:31];
        s3_rsh  <= 6'd32 - s2_lz;
        s3_fail <= s2_eg_fail;
        s3_used <= s2_eg_fail ? 6'd0 : {s2_lz[4:0], 1'b1};
      end else begin
        s3_top  <= {1'b0, s2_bits[63:32]};
        s3_rsh  <= 6'd32 - s2_flen;
        s3_fail <= s2_un_fail;
        s3_used <= s2_un_fail ? 6'd0 : s2_flen;
      end
    end
  end

  // Stage 4: right align; for exp-Golomb the field is codeNum + 1
  assign s3_shifted = s3_top >> s3_rsh;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_op    <= s3_op;
      s4_field <= s3_shifted;
      s4_code  <= s3_shifted - 33'd1;
      s4_fail  <= s3_fail;
      s4_used  <= s3_used;
      s4_total <= {4'd0, s3_off} + {1'b0, s3_used};
    end
  end

  // Stage 5: map the code number to the value of each operation
  assign me_in_range = (s4_code < 33'(CBP_TABLE_SIZE));

  always_comb begin
    value_next  = '0;
    status_next = ST_OK;
    if (s4_fail) begin
      status_next = ST_NOFIT;
    end else begin
      unique case (s4_op)
        OP_UE: value_next = s4_code;
        OP_SE: begin
          if (s4_code[0]) begin
            value_next = {1'b0, s4_field[32:1]};
          end else begin
            value_next = 33'd0 - {1'b0, s4_code[32:1]};
          end
        end
        OP_ME: begin
          if (me_in_range) begin
            value_next = {27'd0, CBP_MAP[s4_code[5:0]]};
          end else begin
            status_next = ST_RANGE;
          end
        end
        OP_UN: value_next = s4_field;
        default: value_next = '0;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      value        <= value_next;
      bits_used    <= s4_used;
      byte_advance <= s4_total[6:3];
      next_offset  <= s4_total[2:0];
      status       <= status_next;
    end
  end

endmodule

### rtl/egd_checker.sv
// Port-level checker for the exp-Golomb field decoder, bound to the top level.
`include "exp_golomb_field_decoder_unit_assert.svh"

module egd_checker
  import egd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [1:0]         op,
  input logic [63:0]        bit_window,
  input logic [2:0]         bit_offset,
  input logic [5:0]         field_length,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [32:0] value,
  input logic [5:0]         bits_used,
  input logic [3:0]         byte_advance,
  input logic [2:0]         next_offset,
  input logic [1:0]         status
);

  // Hold a stalled result
  `EGD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(status))

  // A code that does not fit consumes nothing and yields zero
  `EGD_ASSERT_SAME(a_nofit_empty, out_valid && status == ST_NOFIT, bits_used == 6'd0 && value == 33'sd0 && byte_advance == 4'd0)

  // An out-of-table mapped code yields zero but still consumes its bits
  `EGD_ASSERT_SAME(a_range_zero, out_valid && status == ST_RANGE, value == 33'sd0 && bits_used[0] == 1'b1)

  // The byte advance never leaves the window
  `EGD_ASSERT_SAME(a_adv_bound, out_valid, byte_advance <= 4'd8 && status != ST_RSVD)

endmodule

bind exp_golomb_field_decoder_unit egd_checker u_egd_checker (.*);
